/* sv/tao_pkg.sv */
`default_nettype none
package tao_pkg;

	localparam int NUM_DIMS    = 4;
	localparam int TABLE_DEPTH = 16;

	localparam int MAX_ACTIVE = (NUM_DIMS < 4) ? NUM_DIMS : 4;
	localparam int POS_W      = $clog2(TABLE_DEPTH);
	localparam int LEN_W      = 5;
	localparam int CMP_W      = (LEN_W > POS_W + 1) ? LEN_W : POS_W + 1;
	localparam int CNT_W      = 3;
	localparam int EMIT_W     = 2;
	localparam int DATA_W     = 32;

	// command codes
	localparam logic [1:0] CMD_WR_SPEC  = 2'd0;
	localparam logic [1:0] CMD_WR_TABLE = 2'd1;
	localparam logic [1:0] CMD_INIT     = 2'd2;
	localparam logic [1:0] CMD_ADVANCE  = 2'd3;

	// spec word select codes
	localparam logic [1:0] SEL_BEGIN  = 2'd0;
	localparam logic [1:0] SEL_STEP   = 2'd1;
	localparam logic [1:0] SEL_END    = 2'd2;
	localparam logic [1:0] SEL_LENGTH = 2'd3;

	// dimension kinds
	localparam logic [1:0] KIND_FOR   = 2'd0;
	localparam logic [1:0] KIND_SEQ   = 2'd1;
	localparam logic [1:0] KIND_ASSOC = 2'd2;
	localparam logic [1:0] KIND_UNSUP = 2'd3;

	// register indexes
	localparam logic REG_ACTIVE_DIMS = 1'b0;
	localparam logic REG_DIM_KINDS   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              spec_we;
		logic              tab_we;
		logic [1:0]        sel;
		logic [3:0]        idx;
		logic [DATA_W-1:0] value;
	} cell_wr_t;

	typedef struct packed {
		logic tok;
		logic stop;
		logic perf;
		logic unsup;
	} cell_stat_t;

	function automatic logic [1:0] kind_of(input logic [7:0] kinds, input int d);
		logic [1:0] k;
		k = KIND_FOR;
		if (d < 4) begin
			k = kinds[2*d +: 2];
		end
		return k;
	endfunction

endpackage
`default_nettype wire

/* sv/tao_cmd_if.sv */
`default_nettype none
interface tao_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [1:0]         dim;
	logic [1:0]         field_sel;
	logic [3:0]         entry_index;
	logic signed [31:0] value;

	modport source (
		output valid, command, dim, field_sel, entry_index, value,
		input  ready
	);
	modport sink (
		input  valid, command, dim, field_sel, entry_index, value,
		output ready
	);
endinterface
`default_nettype wire

/* sv/tao_res_if.sv */
`default_nettype none
interface tao_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         dim_index;
	logic signed [31:0] arg_value;
	logic               performed;
	logic               unsupported;
	logic               last;

	modport source (
		output valid, dim_index, arg_value, performed, unsupported, last,
		input  ready
	);
	modport sink (
		input  valid, dim_index, arg_value, performed, unsupported, last,
		output ready
	);
endinterface
`default_nettype wire

/* sv/tao_cell.sv */
`default_nettype none
module tao_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tao_pkg::cell_wr_t     wr,
	input  wire logic                  init_en,
	input  wire logic                  start,
	input  wire logic                  tok_in,
	input  wire logic [1:0]            kind,
	output tao_pkg::cell_stat_t        stat,
	output logic                       carry_o,
	output logic [tao_pkg::DATA_W-1:0] cur_o
);

	logic [tao_pkg::DATA_W-1:0] begin_q;
	logic [tao_pkg::DATA_W-1:0] step_q;
	logic [tao_pkg::DATA_W-1:0] end_q;
	logic [tao_pkg::LEN_W-1:0]  len_q;
	logic [tao_pkg::DATA_W-1:0] table_q [tao_pkg::TABLE_DEPTH];
	logic [tao_pkg::POS_W-1:0]  pos_q;
	logic [tao_pkg::DATA_W-1:0] cur_q;
	logic                       tok_q;

	logic [tao_pkg::POS_W:0]   next_pos;
	logic                      wrap;
	logic [tao_pkg::POS_W-1:0] new_pos;
	logic                      less;
	logic                      carry;
	logic                      perf;
	logic                      unsup;

	always_comb begin
		next_pos = {1'b0, pos_q} + 1'b1;
		wrap = (tao_pkg::CMP_W'(next_pos) >= tao_pkg::CMP_W'(len_q)) ||
			(tao_pkg::CMP_W'(next_pos) >= tao_pkg::CMP_W'(tao_pkg::TABLE_DEPTH));
		new_pos = wrap ? '0 : next_pos[tao_pkg::POS_W-1:0];
		less = $signed(cur_q) < $signed(end_q);
		case (kind)
			tao_pkg::KIND_FOR: begin
				carry = !less;
				perf  = less;
				unsup = 1'b0;
			end
			tao_pkg::KIND_SEQ: begin
				carry = wrap;
				perf  = !wrap;
				unsup = 1'b0;
			end
			tao_pkg::KIND_ASSOC: begin
				carry = 1'b1;
				perf  = 1'b0;
				unsup = 1'b0;
			end
			default: begin
				carry = 1'b0;
				perf  = 1'b0;
				unsup = 1'b1;
			end
		endcase
	end

	assign carry_o    = tok_q & carry;
	assign stat.tok   = tok_q;
	assign stat.stop  = tok_q & !carry;
	assign stat.perf  = tok_q & perf;
	assign stat.unsup = tok_q & unsup;
	assign cur_o      = cur_q;

	// spec words and value table
	always_ff @(posedge clk) begin
		if (wr.spec_we) begin
			case (wr.sel)
				tao_pkg::SEL_BEGIN: begin
					begin_q <= wr.value;
				end
				tao_pkg::SEL_STEP: begin
					step_q <= wr.value;
				end
				tao_pkg::SEL_END: begin
					end_q <= wr.value;
				end
				default: begin
					len_q <= wr.value[tao_pkg::LEN_W-1:0];
				end
			endcase
		end
		if (wr.tab_we && (32'(wr.idx) < tao_pkg::TABLE_DEPTH)) begin
			table_q[tao_pkg::POS_W'(wr.idx)] <= wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cur_q <= '0;
			tok_q <= 1'b0;
		end else begin
			tok_q <= start | tok_in;
			if (init_en) begin
				case (kind)
					tao_pkg::KIND_FOR: begin
						cur_q <= begin_q;
					end
					tao_pkg::KIND_SEQ, tao_pkg::KIND_ASSOC: begin
						cur_q <= table_q[0];
						pos_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (tok_q) begin
				case (kind)
					tao_pkg::KIND_FOR: begin
						cur_q <= less ? cur_q + step_q : begin_q;
					end
					tao_pkg::KIND_SEQ, tao_pkg::KIND_ASSOC: begin
						pos_q <= new_pos;
						cur_q <= table_q[new_pos];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* sv/template_argument_odometer.sv */
// init: one result per cycle for each active dimension while the sink is ready
// advance: a carry walk over 1 to n dimensions (one dimension per cycle), then n results
// one run at a time: commands, writes included, are taken only while idle
// the carry walk through the row of dimension cells sets the advance time
// reset (arst_n, async, active low): idle, no result pending, current values and positions zero
// spec words and value tables hold garbage until written
`default_nettype none
module template_argument_odometer (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tao_cmd_if.sink     cmd,
	tao_res_if.source   res,
	input  wire logic   psel,
	input  wire logic   penable,
	input  wire logic   pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [tao_pkg::CNT_W-1:0] active_q;
	logic [7:0]                kinds_q;

	// sequencer state
	tao_pkg::state_t            state_q, state_d;
	logic [tao_pkg::EMIT_W-1:0] emit_q, emit_d;
	logic                       perf_q, perf_d;
	logic                       unsup_q, unsup_d;

	// output register
	logic                       out_valid_q;
	logic [1:0]                 out_dim_q;
	logic [tao_pkg::DATA_W-1:0] out_value_q;
	logic                       out_perf_q;
	logic                       out_unsup_q;
	logic                       out_last_q;

	logic [tao_pkg::CNT_W-1:0]  n_act;
	logic                       cmd_xfer;
	logic                       load;
	logic                       emit_last;
	logic                       walk_done;
	logic                       walk_perf;
	logic                       walk_unsup;
	logic [tao_pkg::DATA_W-1:0] emit_value;

	tao_pkg::cell_wr_t          cell_wr   [tao_pkg::NUM_DIMS];
	tao_pkg::cell_stat_t        cell_stat [tao_pkg::NUM_DIMS];
	logic [tao_pkg::DATA_W-1:0] cell_cur  [tao_pkg::NUM_DIMS];
	logic [tao_pkg::NUM_DIMS-1:0] cell_init;
	logic [tao_pkg::NUM_DIMS-1:0] cell_start;
	// carry chain, entry d+1 feeds cell d; nothing enters above the last cell
	logic [tao_pkg::NUM_DIMS:0]   carry_w;

	// apb: writes land on the access cycle, reads are plain muxes
	assign pready = 1'b1;

	always_comb begin
		if (paddr[2] == tao_pkg::REG_ACTIVE_DIMS) begin
			prdata = 32'(active_q);
		end else begin
			prdata = 32'(kinds_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= tao_pkg::CNT_W'(1);
			kinds_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == tao_pkg::REG_ACTIVE_DIMS) begin
				active_q <= pwdata[tao_pkg::CNT_W-1:0];
			end else begin
				kinds_q <= pwdata[7:0];
			end
		end
	end

	// effective dimension count: zero acts as one, large values saturate
	always_comb begin
		n_act = active_q;
		if (active_q == '0) begin
			n_act = tao_pkg::CNT_W'(1);
		end
		if (32'(active_q) > tao_pkg::MAX_ACTIVE) begin
			n_act = tao_pkg::CNT_W'(tao_pkg::MAX_ACTIVE);
		end
	end

	assign cmd.ready = (state_q == tao_pkg::ST_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;

	// the row of dimension cells
	assign carry_w[tao_pkg::NUM_DIMS] = 1'b0;

	for (genvar d = 0; d < tao_pkg::NUM_DIMS; d++) begin : g_cell
		always_comb begin
			cell_wr[d].spec_we = cmd_xfer && (cmd.command == tao_pkg::CMD_WR_SPEC) &&
				(32'(cmd.dim) == d);
			cell_wr[d].tab_we  = cmd_xfer && (cmd.command == tao_pkg::CMD_WR_TABLE) &&
				(32'(cmd.dim) == d);
			cell_wr[d].sel     = cmd.field_sel;
			cell_wr[d].idx     = cmd.entry_index;
			cell_wr[d].value   = cmd.value;
		end

		// init touches only active dimensions, the walk starts at the last active one
		assign cell_init[d]  = cmd_xfer && (cmd.command == tao_pkg::CMD_INIT) &&
			(d < 32'(n_act));
		assign cell_start[d] = cmd_xfer && (cmd.command == tao_pkg::CMD_ADVANCE) &&
			(d == 32'(n_act) - 1);

		tao_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (cell_wr[d]),
			.init_en (cell_init[d]),
			.start   (cell_start[d]),
			.tok_in  (carry_w[d+1]),
			.kind    (tao_pkg::kind_of(kinds_q, d)),
			.stat    (cell_stat[d]),
			.carry_o (carry_w[d]),
			.cur_o   (cell_cur[d])
		);
	end

	// walk ends where a cell stops the carry or where the carry falls off dimension 0
	always_comb begin
		walk_done  = carry_w[0];
		walk_perf  = 1'b0;
		walk_unsup = 1'b0;
		for (int d = 0; d < tao_pkg::NUM_DIMS; d++) begin
			walk_done  = walk_done  | cell_stat[d].stop;
			walk_perf  = walk_perf  | cell_stat[d].perf;
			walk_unsup = walk_unsup | cell_stat[d].unsup;
		end
	end

	// result select over the cells
	always_comb begin
		emit_value = '0;
		for (int d = 0; d < tao_pkg::NUM_DIMS; d++) begin
			if (32'(emit_q) == d) begin
				emit_value = cell_cur[d];
			end
		end
	end

	assign emit_last = (tao_pkg::CNT_W'(emit_q) + tao_pkg::CNT_W'(1)) == n_act;
	assign load      = (state_q == tao_pkg::ST_EMIT) && (!out_valid_q || res.ready);

	always_comb begin
		state_d = state_q;
		emit_d  = emit_q;
		perf_d  = perf_q;
		unsup_d = unsup_q;
		case (state_q)
			tao_pkg::ST_IDLE: begin
				if (cmd_xfer && (cmd.command == tao_pkg::CMD_INIT)) begin
					perf_d  = 1'b0;
					unsup_d = 1'b0;
					emit_d  = '0;
					state_d = tao_pkg::ST_EMIT;
				end else if (cmd_xfer && (cmd.command == tao_pkg::CMD_ADVANCE)) begin
					state_d = tao_pkg::ST_WALK;
				end
			end
			tao_pkg::ST_WALK: begin
				if (walk_done) begin
					perf_d  = walk_perf;
					unsup_d = walk_unsup;
					emit_d  = '0;
					state_d = tao_pkg::ST_EMIT;
				end
			end
			tao_pkg::ST_EMIT: begin
				if (load) begin
					emit_d = emit_q + 1'b1;
					if (emit_last) begin
						state_d = tao_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = tao_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tao_pkg::ST_IDLE;
			emit_q  <= '0;
			perf_q  <= 1'b0;
			unsup_q <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_q  <= emit_d;
			perf_q  <= perf_d;
			unsup_q <= unsup_d;
		end
	end

	// output register, holds while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_dim_q   <= 2'(emit_q);
			out_value_q <= emit_value;
			out_perf_q  <= perf_q;
			out_unsup_q <= unsup_q;
			out_last_q  <= emit_last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.dim_index   = out_dim_q;
	assign res.arg_value   = out_value_q;
	assign res.performed   = out_perf_q;
	assign res.unsupported = out_unsup_q;
	assign res.last        = out_last_q;

endmodule
`default_nettype wire

/* sv/tao_checker.sv */
`default_nettype none
module tao_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic [1:0]  cmd_command,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] res_arg_value,
	input wire logic        res_performed,
	input wire logic        res_unsupported,
	input wire logic        res_last
);

	// a stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_arg_value))
		else $error("result changed while stalled");

	// init or advance makes the block busy
	a_busy_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready &&
		(cmd_command == tao_pkg::CMD_INIT || cmd_command == tao_pkg::CMD_ADVANCE)
		|=> !cmd_ready)
		else $error("command taken while a run is in progress");

	// no command is taken between results of one run
	a_no_cmd_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |-> !cmd_ready)
		else $error("ready for commands before the last result");

	// an unsupported walk never reports a move
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_performed && res_unsupported))
		else $error("performed and unsupported both set");

endmodule

bind template_argument_odometer tao_checker u_tao_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_command     (cmd.command),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_arg_value   (res.arg_value),
	.res_performed   (res.performed),
	.res_unsupported (res.unsupported),
	.res_last        (res.last)
);
`default_nettype wire
